### design/fwinfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fwinfo_pkg;

  // Banner capture store
  localparam int BANNER_DEPTH = 95;
  localparam int BANNER_AW    = $clog2(BANNER_DEPTH);
  localparam int BANNER_LW    = 7;

  // Tail store of the most recent image bytes
  localparam int TAIL_DEPTH = 16;
  localparam int TAIL_AW    = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam int TAIL_CW    = $clog2(TAIL_DEPTH + 1);

  // Queue between front and back, and result queue
  localparam int IQ_DEPTH = 2;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [31:0] HASH_ADD     = 32'h9E37_79B9;
  localparam logic [31:0] MARK_LTD     = 32'h4C54_442E;
  localparam logic [31:0] MARK_REV     = 32'h5265_7620;
  localparam logic [6:0]  FALLBACK_LEN = 7'd27;

  localparam logic [7:0] CHAR_LO   = 8'h20;
  localparam logic [7:0] CHAR_HI   = 8'h7E;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;

  // Data map
  localparam logic [7:0] IDX_BANNER_LO = 8'h80;
  localparam logic [7:0] IDX_TAIL_LO   = 8'hE0;
  localparam logic [7:0] IDX_SIG_LO    = 8'hF0;
  localparam logic [7:0] IDX_SIG0      = 8'hF0;
  localparam logic [7:0] IDX_SIG1      = 8'hF1;
  localparam logic [7:0] IDX_SIG2      = 8'hF2;
  localparam logic [7:0] IDX_REV       = 8'hF3;
  localparam logic [7:0] IDX_CNT0      = 8'hF4;
  localparam logic [7:0] IDX_CNT1      = 8'hF5;
  localparam logic [7:0] IDX_CNT2      = 8'hF6;
  localparam logic [7:0] IDX_SUM0      = 8'hF7;
  localparam logic [7:0] IDX_SUM1      = 8'hF8;
  localparam logic [7:0] IDX_MAGIC     = 8'hF9;
  localparam logic [7:0] IDX_SUM2      = 8'hFA;
  localparam logic [7:0] IDX_SUM3      = 8'hFB;
  localparam logic [7:0] IDX_BLEN      = 8'hFC;
  localparam logic [7:0] IDX_RCNT      = 8'hFE;
  localparam logic [7:0] IDX_ID        = 8'hFF;

  localparam logic [7:0] SIG0_BYTE  = 8'h4D;
  localparam logic [7:0] SIG1_BYTE  = 8'h43;
  localparam logic [7:0] SIG2_BYTE  = 8'h55;
  localparam logic [7:0] MAGIC_BYTE = 8'h81;
  localparam logic [7:0] ID_BYTE    = 8'hA5;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_END    = 3'd2,
    CMD_WIDX   = 3'd3,
    CMD_RIDX   = 3'd4,
    CMD_RDATA  = 3'd5,
    CMD_WDATA  = 3'd6,
    CMD_UNUSED = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_CONST  = 2'd0,
    SEL_BANNER = 2'd1,
    SEL_TAIL   = 2'd2
  } sel_t;

  typedef struct packed {
    cmd_t       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       image_loaded;
  } result_t;

  // Banner shown when no printable leading bytes were captured
  function automatic logic [7:0] fallback_byte(input logic [4:0] off);
    logic [7:0] c;
    case (off)
      5'd0:  c = 8'h4D;
      5'd1:  c = 8'h33;
      5'd2:  c = 8'h38;
      5'd3:  c = 8'h32;
      5'd4:  c = 8'h32;
      5'd5:  c = 8'h78;
      5'd6:  c = 8'h20;
      5'd7:  c = 8'h70;
      5'd8:  c = 8'h6F;
      5'd9:  c = 8'h77;
      5'd10: c = 8'h65;
      5'd11: c = 8'h72;
      5'd12: c = 8'h2D;
      5'd13: c = 8'h73;
      5'd14: c = 8'h65;
      5'd15: c = 8'h6E;
      5'd16: c = 8'h73;
      5'd17: c = 8'h65;
      5'd18: c = 8'h20;
      5'd19: c = 8'h66;
      5'd20: c = 8'h69;
      5'd21: c = 8'h72;
      5'd22: c = 8'h6D;
      5'd23: c = 8'h77;
      5'd24: c = 8'h61;
      5'd25: c = 8'h72;
      5'd26: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/fwinfo_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fwinfo_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [2:0]    command,
  input  wire logic [7:0]    image_byte,
  input  wire logic [7:0]    index_value,
  output fwinfo_pkg::item_t  item,
  output logic               item_valid,
  input  wire logic          item_take
);
  import fwinfo_pkg::*;

  item_t             q [IQ_DEPTH];
  logic [IQ_AW-1:0]  wr_ptr;
  logic [IQ_AW-1:0]  rd_ptr;
  logic [IQ_CW-1:0]  count;
  logic              push_ok;
  item_t             incoming;

  assign full       = (count == IQ_CW'(IQ_DEPTH));
  assign push_ok    = push && !full;
  assign item_valid = (count != '0);
  assign item      = q[rd_ptr];

  // Classify: keep the one operand byte that the command uses
  always_comb begin
    incoming.op = cmd_t'(command);
    case (cmd_t'(command))
      CMD_BYTE: incoming.data = image_byte;
      CMD_WIDX: incoming.data = index_value;
      default:  incoming.data = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_take) begin
        rd_ptr <= (rd_ptr == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, item_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/fwinfo_exec.sv
`timescale 1ns / 1ps
`default_nettype none
module fwinfo_exec (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fwinfo_pkg::item_t        item,
  input  wire logic                     item_valid,
  output logic                          item_take,
  input  wire logic [fwinfo_pkg::OQ_CW-1:0] out_count,
  output fwinfo_pkg::result_t           res,
  output logic                          res_valid
);
  import fwinfo_pkg::*;

  logic                  image_valid,    image_valid_next;
  logic [31:0]           byte_count,     byte_count_next;
  logic [31:0]           hash_value,     hash_value_next;
  logic                  capture_open,   capture_open_next;
  logic [BANNER_LW-1:0]  banner_length,  banner_length_next;
  logic [23:0]           recent_chars,   recent_chars_next;
  logic [31:0]           marker_window,  marker_window_next;
  logic [4:0]            pending_digit,  pending_digit_next;
  logic [3:0]            revision_value, revision_value_next;
  logic                  revision_found, revision_found_next;
  logic [TAIL_AW-1:0]    tail_head,      tail_head_next;
  logic [7:0]            index_reg,      index_reg_next;
  logic [7:0]            read_count,     read_count_next;

  logic [7:0]            banner_mem [BANNER_DEPTH];
  logic [7:0]            tail_mem   [TAIL_DEPTH];
  logic [7:0]            banner_rd;
  logic [7:0]            tail_rd;

  logic                  banner_we;
  logic                  tail_we;
  logic [BANNER_AW-1:0]  banner_ra;
  logic [TAIL_AW-1:0]    tail_ra;

  logic [7:0]            b;
  logic                  printable;
  logic [31:0]           last4;
  logic                  rev_found_now;
  logic [7:0]            blen;
  logic [6:0]            off_b;
  logic [3:0]            off_t;
  logic [TAIL_CW-1:0]    tail_fill;
  logic [TAIL_AW-1:0]    tail_start;
  logic [4:0]            tail_sum;
  logic [OQ_CW:0]        in_flight;

  sel_t                  sel;
  logic [7:0]            const_byte;

  logic                  s2_valid;
  sel_t                  s2_sel;
  logic [7:0]            s2_const;
  logic                  s2_loaded;

  // Issue only when the result queue has room for everything in flight
  assign in_flight = (OQ_CW + 1)'(out_count) + (OQ_CW + 1)'(s2_valid);
  assign item_take = item_valid && (in_flight < (OQ_CW + 1)'(OQ_DEPTH));

  assign b         = item.data;
  assign printable = (b >= CHAR_LO) && (b <= CHAR_HI);
  assign last4     = {recent_chars, b};
  assign rev_found_now = revision_found | pending_digit[4];

  assign blen  = (banner_length != '0) ? 8'(banner_length) : 8'(FALLBACK_LEN);
  assign off_b = index_reg[6:0];
  assign off_t = index_reg[3:0];
  assign banner_ra = off_b[BANNER_AW-1:0];

  assign tail_fill  = (byte_count < 32'(TAIL_DEPTH)) ? TAIL_CW'(byte_count)
                                                      : TAIL_CW'(TAIL_DEPTH);
  assign tail_start = (tail_fill < TAIL_CW'(TAIL_DEPTH)) ? '0 : tail_head;
  assign tail_sum   = 5'(tail_start) + 5'(off_t);
  assign tail_ra    = (tail_sum >= 5'(TAIL_DEPTH)) ? TAIL_AW'(tail_sum - 5'(TAIL_DEPTH))
                                                   : TAIL_AW'(tail_sum);

  always_comb begin
    image_valid_next    = image_valid;
    byte_count_next     = byte_count;
    hash_value_next     = hash_value;
    capture_open_next   = capture_open;
    banner_length_next  = banner_length;
    recent_chars_next   = recent_chars;
    marker_window_next  = marker_window;
    pending_digit_next  = pending_digit;
    revision_value_next = revision_value;
    revision_found_next = revision_found;
    tail_head_next      = tail_head;
    index_reg_next      = index_reg;
    read_count_next     = read_count;
    banner_we           = 1'b0;
    tail_we             = 1'b0;
    sel                 = SEL_CONST;
    const_byte          = 8'h00;

    if (item_take) begin
      case (item.op)
        CMD_BEGIN: begin
          image_valid_next    = 1'b0;
          byte_count_next     = '0;
          hash_value_next     = '0;
          capture_open_next   = 1'b1;
          banner_length_next  = '0;
          recent_chars_next   = '0;
          marker_window_next  = '0;
          pending_digit_next  = '0;
          revision_value_next = '0;
          revision_found_next = 1'b0;
          tail_head_next      = '0;
        end
        CMD_BYTE: begin
          if (!image_valid) begin
            if (byte_count != 32'hFFFF_FFFF) begin
              byte_count_next = byte_count + 32'd1;
            end
            hash_value_next = ({hash_value[26:0], hash_value[31:27]} ^ {24'd0, b})
                              + HASH_ADD;

            if (capture_open) begin
              if (!printable) begin
                capture_open_next = 1'b0;
              end else begin
                if (banner_length < BANNER_LW'(BANNER_DEPTH)) begin
                  banner_we = 1'b1;
                end
                banner_length_next = banner_length + 1'b1;
                recent_chars_next  = last4[23:0];
                if (last4 == MARK_LTD ||
                    banner_length_next >= BANNER_LW'(BANNER_DEPTH)) begin
                  capture_open_next = 1'b0;
                end
              end
            end

            // Commit the digit once a byte follows it
            if (!revision_found && pending_digit[4]) begin
              revision_value_next = pending_digit[3:0];
              revision_found_next = 1'b1;
            end
            pending_digit_next = '0;
            if (!rev_found_now && marker_window == MARK_REV &&
                b >= DIGIT_LO && b <= DIGIT_HI) begin
              pending_digit_next = {1'b1, b[3:0]};
            end
            marker_window_next = {marker_window[23:0], b};

            tail_we        = 1'b1;
            tail_head_next = (tail_head == TAIL_AW'(TAIL_DEPTH - 1)) ? '0
                                                                     : tail_head + 1'b1;
          end
        end
        CMD_END: begin
          image_valid_next = (byte_count != '0);
        end
        CMD_WIDX: begin
          index_reg_next = b;
        end
        CMD_RIDX: begin
          const_byte = index_reg;
        end
        CMD_RDATA: begin
          read_count_next = read_count + 8'd1;
          if (image_valid) begin
            if (index_reg >= IDX_BANNER_LO && index_reg < IDX_TAIL_LO) begin
              if (8'(off_b) < blen) begin
                if (banner_length == '0) begin
                  const_byte = fallback_byte(off_b[4:0]);
                end else begin
                  sel = SEL_BANNER;
                end
              end
            end else if (index_reg >= IDX_TAIL_LO && index_reg < IDX_SIG_LO) begin
              if (5'(off_t) < 5'(tail_fill)) begin
                sel = SEL_TAIL;
              end
            end else begin
              case (index_reg)
                IDX_SIG0:  const_byte = SIG0_BYTE;
                IDX_SIG1:  const_byte = SIG1_BYTE;
                IDX_SIG2:  const_byte = SIG2_BYTE;
                IDX_REV:   const_byte = {4'd0, revision_value};
                IDX_CNT0:  const_byte = byte_count[7:0];
                IDX_CNT1:  const_byte = byte_count[15:8];
                IDX_CNT2:  const_byte = byte_count[23:16];
                IDX_SUM0:  const_byte = hash_value[7:0];
                IDX_SUM1:  const_byte = hash_value[15:8];
                IDX_MAGIC: const_byte = MAGIC_BYTE;
                IDX_SUM2:  const_byte = hash_value[23:16];
                IDX_SUM3:  const_byte = hash_value[31:24];
                IDX_BLEN:  const_byte = blen;
                IDX_RCNT:  const_byte = read_count_next;
                IDX_ID:    const_byte = ID_BYTE;
                default:   const_byte = 8'h00;
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stores: written on image bytes, read with a registered port on issue
  always_ff @(posedge clk) begin
    if (banner_we) begin
      banner_mem[banner_length[BANNER_AW-1:0]] <= b;
    end
    if (tail_we) begin
      tail_mem[tail_head] <= b;
    end
    if (item_take) begin
      banner_rd <= banner_mem[banner_ra];
      tail_rd   <= tail_mem[tail_ra];
      s2_sel    <= sel;
      s2_const  <= const_byte;
      s2_loaded <= image_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_valid    <= 1'b0;
      byte_count     <= '0;
      hash_value     <= '0;
      capture_open   <= 1'b1;
      banner_length  <= '0;
      recent_chars   <= '0;
      marker_window  <= '0;
      pending_digit  <= '0;
      revision_value <= '0;
      revision_found <= 1'b0;
      tail_head      <= '0;
      index_reg      <= '0;
      read_count     <= '0;
      s2_valid       <= 1'b0;
    end else begin
      image_valid    <= image_valid_next;
      byte_count     <= byte_count_next;
      hash_value     <= hash_value_next;
      capture_open   <= capture_open_next;
      banner_length  <= banner_length_next;
      recent_chars   <= recent_chars_next;
      marker_window  <= marker_window_next;
      pending_digit  <= pending_digit_next;
      revision_value <= revision_value_next;
      revision_found <= revision_found_next;
      tail_head      <= tail_head_next;
      index_reg      <= index_reg_next;
      read_count     <= read_count_next;
      s2_valid       <= item_take;
    end
  end

  assign res_valid = s2_valid;

  always_comb begin
    res.image_loaded = s2_loaded;
    case (s2_sel)
      SEL_BANNER: res.read_data = banner_rd;
      SEL_TAIL:   res.read_data = tail_rd;
      default:    res.read_data = s2_const;
    endcase
  end

endmodule
`default_nettype wire

### design/fwinfo_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module fwinfo_outq (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fwinfo_pkg::result_t      res,
  input  wire logic                     res_valid,
  output logic [fwinfo_pkg::OQ_CW-1:0]  count,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [7:0]                    read_data,
  output logic                          image_loaded
);
  import fwinfo_pkg::*;

  result_t           q [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_ptr;
  logic [OQ_AW-1:0]  rd_ptr;
  logic              pop_ok;

  assign empty        = (count == '0);
  assign pop_ok       = pop && !empty;
  assign read_data    = q[rd_ptr].read_data;
  assign image_loaded = q[rd_ptr].image_loaded;

  // The back end reserves a slot before issue, so a push never overflows
  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= (wr_ptr == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({res_valid, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/firmware_info_register_port.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Side     Handshake          Fields
// -------   ------   ----------------   ---------------------------------------
// input     sink     push / full        command[2:0] image_byte[7:0] index_value[7:0]
// result    source   pop / empty        read_data[7:0] image_loaded
//
// One word in, one result word out, at one word per cycle sustained while
// the result side pops. An accepted input word is written into the input
// queue, then runs the execute stage and its registered store read once the
// back end takes it, and its result is then written into the result queue,
// where it shows on the result ports.
// Reset (rst, synchronous) empties both queues and clears the image state;
// the banner and tail stores keep their contents and are never read unwritten.
// A stalled result side backs up the four-entry result queue, then the
// two-entry input queue, and only then raises full.
module firmware_info_register_port (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  image_byte,
  input  wire logic [7:0]  index_value,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data,
  output logic             image_loaded
);
  import fwinfo_pkg::*;

  item_t             item;
  logic              item_valid;
  logic              item_take;
  result_t           res;
  logic              res_valid;
  logic [OQ_CW-1:0]  out_count;

  // Front: accept the word, pick its operand byte, hold it in a short queue
  fwinfo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .image_byte  (image_byte),
    .index_value (index_value),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take)
  );

  // Back: update image state, checksum and stores; look up the read byte.
  // It takes a word only when the result queue has a slot reserved for it.
  fwinfo_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .out_count  (out_count),
    .res        (res),
    .res_valid  (res_valid)
  );

  // Result queue: hold finished words until the consumer pops them
  fwinfo_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .res_valid    (res_valid),
    .count        (out_count),
    .empty        (empty),
    .pop          (pop),
    .read_data    (read_data),
    .image_loaded (image_loaded)
  );

endmodule
`default_nettype wire

### design/fwinfo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fwinfo_protocol_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  read_data,
  input wire logic        image_loaded
);

  // Both queues come out of reset empty
  a_reset_clean: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A word taken while the result side is drained shows up as a waiting result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty) |-> ##3 !empty)
    else $error("result word missing after input word");

  // A waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(image_loaded)))
    else $error("waiting result word changed");

endmodule

bind firmware_info_register_port fwinfo_protocol_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .read_data    (read_data),
  .image_loaded (image_loaded)
);
`default_nettype wire

### test/fwinfo_checker.sv
`timescale 1ns / 1ps
module fwinfo_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [2:0] command,
  input  wire logic [7:0] image_byte,
  input  wire logic [7:0] index_value,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] read_data,
  input  wire logic       image_loaded,
  output int              fault_total,
  output int              pending_words
);
  import fwinfo_pkg::*;

  // Banner text returned when nothing printable was captured
  localparam logic [27*8-1:0] DEFAULT_BANNER =
    216'h4D333832327820706F7765722D73656E7365206669726D77617265;

  logic        loaded;
  logic [31:0] count;
  logic [31:0] sum;
  logic        cap_open;
  logic [7:0]  banner_mem [BANNER_DEPTH];
  logic [6:0]  banner_len;
  logic [23:0] last3;
  logic [31:0] mark_win;
  logic [4:0]  digit_hold;
  logic [3:0]  rev;
  logic        rev_seen;
  logic [7:0]  tail_mem [TAIL_DEPTH];
  int          tail_wr;
  logic [7:0]  idx;
  logic [7:0]  reads;
  result_t     awaited_words [$];

  function automatic void restart_image();
    loaded     = 1'b0;
    count      = '0;
    sum        = '0;
    cap_open   = 1'b1;
    banner_len = '0;
    last3      = '0;
    mark_win   = '0;
    digit_hold = '0;
    rev        = '0;
    rev_seen   = 1'b0;
    tail_wr    = 0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] last4;
    if (count != '1) count++;
    sum = ({sum[26:0], sum[31:27]} ^ {24'h0, b}) + HASH_ADD;

    if (cap_open) begin
      if (b < CHAR_LO || b > CHAR_HI) begin
        cap_open = 1'b0;
      end else begin
        last4 = {last3, b};
        if (banner_len < BANNER_DEPTH) banner_mem[banner_len] = b;
        banner_len++;
        last3 = last4[23:0];
        if (last4 == MARK_LTD || banner_len >= BANNER_DEPTH) cap_open = 1'b0;
      end
    end

    // A digit after the marker only counts once one more byte shows up
    if (!rev_seen && digit_hold[4]) begin
      rev      = digit_hold[3:0];
      rev_seen = 1'b1;
    end
    digit_hold = '0;
    if (!rev_seen && mark_win == MARK_REV && b >= DIGIT_LO && b <= DIGIT_HI)
      digit_hold = {1'b1, b[3:0]};
    mark_win = {mark_win[23:0], b};

    tail_mem[tail_wr] = b;
    tail_wr = (tail_wr + 1) % TAIL_DEPTH;
  endfunction

  function automatic logic [7:0] indexed_byte();
    logic [6:0] blen;
    logic [7:0] off;
    int         fill;
    int         start;
    logic [7:0] value;
    value = 8'h00;
    blen  = (banner_len != 0) ? banner_len : FALLBACK_LEN;
    if (!loaded) return 8'h00;
    if (idx >= IDX_BANNER_LO && idx < IDX_TAIL_LO) begin
      off = idx - IDX_BANNER_LO;
      if (off >= blen) value = 8'h00;
      else if (banner_len == 0) value = DEFAULT_BANNER[(26 - off) * 8 +: 8];
      else value = banner_mem[off];
    end else if (idx >= IDX_TAIL_LO && idx < IDX_SIG_LO) begin
      off   = idx - IDX_TAIL_LO;
      fill  = (count < TAIL_DEPTH) ? int'(count[7:0]) : TAIL_DEPTH;
      start = (fill < TAIL_DEPTH) ? 0 : tail_wr;
      if (off < fill) value = tail_mem[(start + off) % TAIL_DEPTH];
    end else begin
      case (idx)
        IDX_SIG0:  value = SIG0_BYTE;
        IDX_SIG1:  value = SIG1_BYTE;
        IDX_SIG2:  value = SIG2_BYTE;
        IDX_REV:   value = {4'h0, rev};
        IDX_CNT0:  value = count[7:0];
        IDX_CNT1:  value = count[15:8];
        IDX_CNT2:  value = count[23:16];
        IDX_SUM0:  value = sum[7:0];
        IDX_SUM1:  value = sum[15:8];
        IDX_MAGIC: value = MAGIC_BYTE;
        IDX_SUM2:  value = sum[23:16];
        IDX_SUM3:  value = sum[31:24];
        IDX_BLEN:  value = {1'b0, blen};
        IDX_RCNT:  value = reads;
        IDX_ID:    value = ID_BYTE;
        default:   value = 8'h00;
      endcase
    end
    return value;
  endfunction

  function automatic result_t apply_command(input logic [2:0] code, input logic [7:0] b,
                                            input logic [7:0] i);
    result_t r;
    r.read_data = 8'h00;
    case (cmd_t'(code))
      CMD_BEGIN: restart_image();
      CMD_BYTE:  if (!loaded) absorb_byte(b);
      CMD_END:   loaded = (count != 0);
      CMD_WIDX:  idx = i;
      CMD_RIDX:  r.read_data = idx;
      CMD_RDATA: begin
        reads++;
        r.read_data = indexed_byte();
      end
      default: ;
    endcase
    r.image_loaded = loaded;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      k;
    if (rst) begin
      restart_image();
      idx   = '0;
      reads = '0;
      for (k = 0; k < BANNER_DEPTH; k++) banner_mem[k] = 8'h00;
      for (k = 0; k < TAIL_DEPTH; k++) tail_mem[k] = 8'h00;
      awaited_words.delete();
    end else begin
      // Check the outgoing word before queueing the incoming one
      if (pop && !empty) begin
        if (awaited_words.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("unexpected result word: read_data=%02h image_loaded=%0b",
                     read_data, image_loaded);
        end else begin
          want = awaited_words.pop_front();
          if (read_data !== want.read_data || image_loaded !== want.image_loaded) begin
            fault_total++;
            if (fault_total <= 10)
              $display("mismatch: read_data exp %02h got %02h, image_loaded exp %0b got %0b",
                       want.read_data, read_data, want.image_loaded, image_loaded);
          end
        end
      end
      if (push && !full)
        awaited_words.insert(awaited_words.size(),
                             apply_command(command, image_byte, index_value));
    end
    pending_words <= awaited_words.size();
  end

endmodule

### test/tb_firmware_info_register_port.sv
`timescale 1ns / 1ps
module tb_firmware_info_register_port;
  import fwinfo_pkg::*;

  logic       clk;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic       pop         = 1'b0;
  logic [2:0] command     = CMD_BEGIN;
  logic [7:0] image_byte  = 8'h00;
  logic [7:0] index_value = 8'h00;
  logic       full;
  logic       empty;
  logic [7:0] read_data;
  logic       image_loaded;

  int fault_total;
  int pending_words;
  int words_sent = 0;
  int pop_hold   = 0;
  bit calm       = 1'b0;

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  firmware_info_register_port u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .image_byte   (image_byte),
    .index_value  (index_value),
    .empty        (empty),
    .pop          (pop),
    .read_data    (read_data),
    .image_loaded (image_loaded)
  );

  // Watch both channels, predict every result word and compare
  fwinfo_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .image_byte    (image_byte),
    .index_value   (index_value),
    .empty         (empty),
    .pop           (pop),
    .read_data     (read_data),
    .image_loaded  (image_loaded),
    .fault_total   (fault_total),
    .pending_words (pending_words)
  );

  // Result side: pop by default, stall in random bursts until the calm tail.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      pop <= 1'b0;
      pop_hold = int'($urandom_range(1, 16)) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Present one word and hold it until the block takes it. A random idle
  // burst may come first; push stays high between back-to-back words.
  task automatic send_word(input cmd_t op, input logic [7:0] b, input logic [7:0] i);
    if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push        <= 1'b1;
    command     <= op;
    image_byte  <= b;
    index_value <= i;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    // Run the last stretch of the test without any idling
    if (words_sent > 470) calm = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_bare(input cmd_t op);
    send_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Frame an image of about len bytes. Mix printable text with the cut and
  // revision markers and some arbitrary bytes; plain images hold printable
  // text only so the banner runs into its depth limit.
  task automatic stream_image(input int len, input bit framed, input bit plain);
    logic [7:0] img [$];
    int         pick;
    int         k;
    if (framed) send_bare(CMD_BEGIN);
    while (img.size() < len) begin
      pick = plain ? 19 : $urandom_range(0, 19);
      if (pick == 0) begin
        for (k = 3; k >= 0; k--) img.insert(img.size(), MARK_LTD[k*8 +: 8]);
      end else if (pick == 1) begin
        for (k = 3; k >= 0; k--) img.insert(img.size(), MARK_REV[k*8 +: 8]);
        img.insert(img.size(), 8'(DIGIT_LO + $urandom_range(0, 9)));
      end else if (pick == 2) begin
        img.insert(img.size(), 8'($urandom_range(0, 255)));
      end else begin
        img.insert(img.size(), 8'($urandom_range(CHAR_LO, CHAR_HI)));
      end
    end
    // End on a revision digit: with no byte after it, it must not count
    if (!plain && len > 0 && $urandom_range(0, 5) == 0) begin
      for (k = 3; k >= 0; k--) img.insert(img.size(), MARK_REV[k*8 +: 8]);
      img.insert(img.size(), 8'(DIGIT_LO + $urandom_range(0, 9)));
    end
    // Open on a non-printable byte so the banner stays empty
    if (!plain && img.size() > 0 && $urandom_range(0, 6) == 0)
      img[0] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                    : 8'($urandom_range(8'h7F, 8'hFF));
    foreach (img[n]) send_byte(img[n]);
    send_bare(CMD_END);
  endtask

  // Read back a handful of registers across the whole data map
  task automatic probe_registers();
    int         pick;
    logic [7:0] target;
    repeat ($urandom_range(3, 10)) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) target = 8'(IDX_BANNER_LO + $urandom_range(0, 99));
      else if (pick <= 4) target = 8'(IDX_TAIL_LO + $urandom_range(0, 15));
      else if (pick <= 7) target = 8'(IDX_SIG_LO + $urandom_range(0, 15));
      else if (pick == 8) target = 8'($urandom_range(0, 255));
      else target = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_word(CMD_WIDX, 8'($urandom_range(0, 255)), target);
      repeat ($urandom_range(1, 2)) send_bare(CMD_RDATA);
      if ($urandom_range(0, 3) == 0) send_bare(CMD_RIDX);
      // Stray byte after the end: dropped while an image is loaded
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int pick;
    int len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Nothing loaded yet: data reads return zero
    send_bare(CMD_RDATA);
    send_word(CMD_WDATA, 8'hFF, 8'hFF);
    send_word(CMD_UNUSED, 8'hFF, 8'hFF);
    // End with no bytes taken leaves the image unloaded
    send_bare(CMD_END);
    // Bytes straight after reset, no begin: "Rev 7LTD." then a zero byte
    send_byte(8'h52);
    send_byte(8'h65);
    send_byte(8'h76);
    send_byte(8'h20);
    send_byte(8'h37);
    send_byte(8'h4C);
    send_byte(8'h54);
    send_byte(8'h44);
    send_byte(8'h2E);
    send_byte(8'h00);
    send_bare(CMD_END);
    send_word(CMD_WIDX, 8'h00, IDX_BLEN);
    send_bare(CMD_RIDX);
    send_bare(CMD_RDATA);
    // Loaded image ignores further bytes
    send_byte(8'hFF);
    // Non-printable first byte: the default banner shows through
    send_bare(CMD_BEGIN);
    send_byte(8'h00);
    send_bare(CMD_END);
    send_word(CMD_WIDX, 8'hFF, IDX_BANNER_LO);
    send_bare(CMD_RDATA);

    // Mostly framed images followed by readback, some raw command noise
    while (words_sent < 550) begin
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(96, 130);
        else len = $urandom_range(1, 24);
        stream_image(len, $urandom_range(0, 9) != 0, pick == 1);
        probe_registers();
      end else begin
        repeat ($urandom_range(3, 10))
          send_word(cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
    end
    push <= 1'b0;

    // Let the last accepted word reach the checker, then drain
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fault_total == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/fwinfo_pkg.sv
design/fwinfo_front.sv
design/fwinfo_exec.sv
design/fwinfo_outq.sv
design/firmware_info_register_port.sv
design/fwinfo_checker.sv
test/fwinfo_checker.sv
test/tb_firmware_info_register_port.sv
